// ----- design/lamport_mutex_node_defines.svh -----
// Assertion macros used by the checker in design/lmn_checker.sv.
`ifndef LAMPORT_MUTEX_NODE_DEFINES_SVH
`define LAMPORT_MUTEX_NODE_DEFINES_SVH

// Same-cycle implication, reset gated.
`define LMN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset gated.
`define LMN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lmn_pkg.sv -----
package lmn_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int SCAN_W    = NODE_W + 1;
    localparam int TIME_W    = 32;
    localparam int OK_W      = 5;
    localparam int CNT_W     = OK_W + 1;

    localparam logic [TIME_W-1:0] TIME_MAX    = '1;
    localparam logic [OK_W-1:0]   OKCOUNT_MAX = '1;

    typedef logic [NODE_W-1:0] lmn_idx_t;
    typedef logic [TIME_W-1:0] lmn_time_t;

    typedef enum logic [2:0] {
        CMD_LOCK    = 3'd0,
        CMD_UNLOCK  = 3'd1,
        CMD_REQ     = 3'd2,
        CMD_OK      = 3'd3,
        CMD_RELEASE = 3'd4
    } lmn_cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_REQ     = 2'd1,
        ACT_OK      = 2'd2,
        ACT_RELEASE = 2'd3
    } lmn_act_t;

    typedef enum logic {
        CFG_OWN_NODE   = 1'b0,
        CFG_NODE_COUNT = 1'b1
    } lmn_cfg_idx_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  source_node;
        logic [31:0] msg_time;
    } lmn_in_t;

    typedef struct packed {
        logic [1:0]  send_action;
        logic [3:0]  dest_node;
        logic [31:0] send_time;
        logic        grant;
    } lmn_out_t;

endpackage

// ----- design/lamport_mutex_node.sv -----
// The result strobe is registered after the EXEC and RD_OWN states when no grant test is
// needed, and after EXEC, RD_OWN and SCAN when the own request is pending with enough OKs.
// Busy holds off new items until the result is out; the head search reads the request table
// one entry a cycle through a single registered read port and one comparator.
// The result is shown for one cycle; a new item may start in that cycle.
// Reset clears clocks, counts, flags and all table valid bits at once: no clearing pass.
module lamport_mutex_node (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  lmn_pkg::lmn_in_t msg,
    output logic             result_valid,
    output lmn_pkg::lmn_out_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [4:0]       cfg_data
);
    import lmn_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_OWN,
        ST_SCAN
    } state_t;

    state_t              state_reg, state_next;
    lmn_in_t             msg_reg, msg_next;
    logic [3:0]          own_node_reg, own_node_next;
    logic [4:0]          node_count_reg, node_count_next;
    logic [MAX_NODES-1:0] valid_reg, valid_next;
    lmn_time_t           clock_reg, clock_next;
    lmn_time_t           max_seen_reg, max_seen_next;
    logic [OK_W-1:0]     ok_count_reg, ok_count_next;
    logic                waiting_reg, waiting_next;
    logic                holding_reg, holding_next;
    logic [SCAN_W-1:0]   scan_idx_reg, scan_idx_next;
    lmn_time_t           own_time_reg, own_time_next;
    logic                lose_reg, lose_next;
    lmn_out_t            result_reg, result_next;
    logic                result_valid_reg, result_valid_next;

    lmn_idx_t            me;
    lmn_idx_t            src_idx;
    logic                src_ok;
    lmn_time_t           clock_inc;
    lmn_time_t           seen_inc;
    logic [CNT_W-1:0]    active;
    logic [CNT_W-1:0]    ok_plus;
    logic                grant_ready;

    logic                wr_en;
    lmn_idx_t            wr_addr;
    lmn_time_t           wr_data;
    lmn_idx_t            rd_addr;
    lmn_time_t           rd_data;

    lmn_idx_t            entry_idx;
    logic                ahead;

    assign me        = NODE_W'(32'(own_node_reg) % MAX_NODES);
    assign src_idx   = NODE_W'(msg_reg.source_node);
    assign src_ok    = (32'(msg_reg.source_node) < MAX_NODES) &&
                       (msg_reg.source_node != own_node_reg);
    assign clock_inc = (clock_reg == TIME_MAX) ? TIME_MAX : clock_reg + 1'b1;
    assign seen_inc  = (max_seen_reg == TIME_MAX) ? TIME_MAX : max_seen_reg + 1'b1;
    assign entry_idx = NODE_W'(scan_idx_reg - 1'b1);
    assign ok_plus   = {1'b0, ok_count_reg} + 1'b1;

    always_comb
    begin
        priority if (node_count_reg == '0)
        begin
            active = CNT_W'(1);
        end
        else if (32'(node_count_reg) > MAX_NODES)
        begin
            active = CNT_W'(MAX_NODES);
        end
        else
        begin
            active = {1'b0, node_count_reg};
        end
    end

    assign grant_ready = waiting_reg && valid_reg[me] && (ok_plus >= active);

    lmn_req_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lmn_head_cmp u_cmp (
        .entry_valid (valid_reg[entry_idx]),
        .entry_idx   (entry_idx),
        .entry_time  (rd_data),
        .own_idx     (me),
        .own_time    (own_time_reg),
        .ahead       (ahead)
    );

    always_comb
    begin
        state_next        = state_reg;
        msg_next          = msg_reg;
        own_node_next     = own_node_reg;
        node_count_next   = node_count_reg;
        valid_next        = valid_reg;
        clock_next        = clock_reg;
        max_seen_next     = max_seen_reg;
        ok_count_next     = ok_count_reg;
        waiting_next      = waiting_reg;
        holding_next      = holding_reg;
        scan_idx_next     = scan_idx_reg;
        own_time_next     = own_time_reg;
        lose_next         = lose_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = me;
        wr_data           = clock_inc;
        rd_addr           = me;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OWN_NODE:   own_node_next   = cfg_data[3:0];
                CFG_NODE_COUNT: node_count_next = cfg_data;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    msg_next   = msg;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                result_next = '0;
                unique case (msg_reg.command)
                    CMD_LOCK:
                    begin
                        if (!waiting_reg && !holding_reg)
                        begin
                            clock_next              = clock_inc;
                            wr_en                   = 1'b1;
                            valid_next[me]          = 1'b1;
                            ok_count_next           = '0;
                            waiting_next            = 1'b1;
                            result_next.send_action = ACT_REQ;
                            result_next.send_time   = clock_inc;
                        end
                    end
                    CMD_UNLOCK:
                    begin
                        if (holding_reg)
                        begin
                            valid_next[me]          = 1'b0;
                            holding_next            = 1'b0;
                            result_next.send_action = ACT_RELEASE;
                            result_next.send_time   = clock_reg;
                            if (seen_inc > clock_reg)
                            begin
                                clock_next = seen_inc;
                            end
                        end
                    end
                    CMD_REQ, CMD_OK, CMD_RELEASE:
                    begin
                        if (src_ok)
                        begin
                            if (msg_reg.msg_time > max_seen_reg)
                            begin
                                max_seen_next = msg_reg.msg_time;
                            end
                            unique case (msg_reg.command)
                                CMD_REQ:
                                begin
                                    wr_en                   = 1'b1;
                                    wr_addr                 = src_idx;
                                    wr_data                 = msg_reg.msg_time;
                                    valid_next[src_idx]     = 1'b1;
                                    result_next.send_action = ACT_OK;
                                    result_next.dest_node   = msg_reg.source_node;
                                    result_next.send_time   = clock_reg;
                                end
                                CMD_OK:
                                begin
                                    if (ok_count_reg != OKCOUNT_MAX)
                                    begin
                                        ok_count_next = ok_count_reg + 1'b1;
                                    end
                                end
                                default:
                                begin
                                    valid_next[src_idx] = 1'b0;
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_RD_OWN;
            end
            ST_RD_OWN:
            begin
                if (grant_ready)
                begin
                    scan_idx_next = '0;
                    lose_next     = 1'b0;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                rd_addr = scan_idx_reg[NODE_W-1:0];
                if (scan_idx_reg == '0)
                begin
                    own_time_next = rd_data;
                end
                else if (ahead)
                begin
                    lose_next = 1'b1;
                end
                if (scan_idx_reg == SCAN_W'(MAX_NODES))
                begin
                    if (!(lose_reg || ahead))
                    begin
                        waiting_next      = 1'b0;
                        holding_next      = 1'b1;
                        result_next.grant = 1'b1;
                    end
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            own_node_reg     <= '0;
            node_count_reg   <= 5'd1;
            valid_reg        <= '0;
            clock_reg        <= '0;
            max_seen_reg     <= '0;
            ok_count_reg     <= '0;
            waiting_reg      <= 1'b0;
            holding_reg      <= 1'b0;
            scan_idx_reg     <= '0;
            lose_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            own_node_reg     <= own_node_next;
            node_count_reg   <= node_count_next;
            valid_reg        <= valid_next;
            clock_reg        <= clock_next;
            max_seen_reg     <= max_seen_next;
            ok_count_reg     <= ok_count_next;
            waiting_reg      <= waiting_next;
            holding_reg      <= holding_next;
            scan_idx_reg     <= scan_idx_next;
            lose_reg         <= lose_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg      <= msg_next;
        own_time_reg <= own_time_next;
        result_reg   <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- design/lmn_req_ram.sv -----
module lmn_req_ram (
    input  logic              clk,
    input  logic              wr_en,
    input  lmn_pkg::lmn_idx_t  wr_addr,
    input  lmn_pkg::lmn_time_t wr_data,
    input  lmn_pkg::lmn_idx_t  rd_addr,
    output lmn_pkg::lmn_time_t rd_data
);
    import lmn_pkg::*;

    lmn_time_t mem [MAX_NODES];
    lmn_time_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/lmn_head_cmp.sv -----
module lmn_head_cmp (
    input  logic               entry_valid,
    input  lmn_pkg::lmn_idx_t  entry_idx,
    input  lmn_pkg::lmn_time_t entry_time,
    input  lmn_pkg::lmn_idx_t  own_idx,
    input  lmn_pkg::lmn_time_t own_time,
    output logic               ahead
);
    import lmn_pkg::*;

    logic earlier;

    assign earlier = (entry_time < own_time) ||
                     ((entry_time == own_time) && (entry_idx < own_idx));
    assign ahead   = entry_valid && (entry_idx != own_idx) && earlier;

endmodule

// ----- design/lmn_checker.sv -----
`include "lamport_mutex_node_defines.svh"

module lmn_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input lmn_pkg::lmn_out_t result
);
    import lmn_pkg::*;

    `LMN_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted item did not raise busy")
    `LMN_ASSERT_NEXT(a_strobe_single, clk, rst_n, result_valid, !result_valid, "result strobe held over two cycles")
    `LMN_ASSERT_NOW(a_idle_clean, clk, rst_n, result_valid && (result.send_action == ACT_NONE), (result.send_time == '0) && (result.dest_node == '0), "idle result carries payload")
    `LMN_ASSERT_NOW(a_grant_not_release, clk, rst_n, result_valid && result.grant, result.send_action != ACT_RELEASE, "grant given on release")

endmodule

bind lamport_mutex_node lmn_checker u_lmn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

// ----- tb/lamport_mutex_node_checker.sv -----
`timescale 1ns / 100ps

module lamport_mutex_node_checker
    import lmn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  lmn_in_t     msg,
    input  logic        result_valid,
    input  lmn_out_t    result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    output int unsigned fail_count,
    output int unsigned outstanding
);

    lmn_time_t       req_time  [MAX_NODES];
    logic            req_valid [MAX_NODES];
    lmn_time_t       lclock;
    lmn_time_t       max_seen;
    logic [OK_W-1:0] ok_seen;
    logic            want_lock;
    logic            holding;
    lmn_idx_t        own_id;
    logic [4:0]      nodes_cfg;
    lmn_out_t        sends_due[$];
    int unsigned     errs;

    assign fail_count = errs;

    function automatic bit own_request_first();
        bit first;
        first = req_valid[own_id];
        for (int i = 0; i < MAX_NODES; i++)
            if (i != own_id && req_valid[i] &&
                (req_time[i] < req_time[own_id] ||
                 (req_time[i] == req_time[own_id] && i < own_id)))
                first = 1'b0;
        return first;
    endfunction

    function automatic int participants();
        if (nodes_cfg == 0)
            return 1;
        if (nodes_cfg > MAX_NODES)
            return MAX_NODES;
        return int'(nodes_cfg);
    endfunction

    function automatic lmn_out_t apply_event(lmn_in_t ev);
        lmn_out_t  res;
        lmn_time_t bumped;
        res = '0;
        case (ev.command)
            CMD_LOCK:
                if (!want_lock && !holding)
                begin
                    if (lclock != TIME_MAX)
                        lclock = lclock + 1;
                    req_time[own_id]  = lclock;
                    req_valid[own_id] = 1'b1;
                    ok_seen           = '0;
                    want_lock         = 1'b1;
                    res.send_action   = ACT_REQ;
                    res.send_time     = lclock;
                end
            CMD_UNLOCK:
                if (holding)
                begin
                    bumped            = (max_seen == TIME_MAX) ? TIME_MAX : max_seen + 1;
                    req_valid[own_id] = 1'b0;
                    holding           = 1'b0;
                    res.send_action   = ACT_RELEASE;
                    res.send_time     = lclock;
                    if (bumped > lclock)
                        lclock = bumped;
                end
            CMD_REQ, CMD_OK, CMD_RELEASE:
                if (ev.source_node != own_id)
                begin
                    if (ev.msg_time > max_seen)
                        max_seen = ev.msg_time;
                    if (ev.command == CMD_REQ)
                    begin
                        req_time[ev.source_node]  = ev.msg_time;
                        req_valid[ev.source_node] = 1'b1;
                        res.send_action           = ACT_OK;
                        res.dest_node             = ev.source_node;
                        res.send_time             = lclock;
                    end
                    else if (ev.command == CMD_OK)
                    begin
                        if (ok_seen != OKCOUNT_MAX)
                            ok_seen = ok_seen + 1'b1;
                    end
                    else
                        req_valid[ev.source_node] = 1'b0;
                end
            default: ;
        endcase
        if (want_lock && own_request_first() && int'(ok_seen) + 1 >= participants())
        begin
            want_lock = 1'b0;
            holding   = 1'b1;
            res.grant = 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        lmn_out_t due;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NODES; i++)
            begin
                req_time[i]  = '0;
                req_valid[i] = 1'b0;
            end
            lclock    = '0;
            max_seen  = '0;
            ok_seen   = '0;
            want_lock = 1'b0;
            holding   = 1'b0;
            own_id    = '0;
            nodes_cfg = 5'd1;
            errs      = 0;
            sends_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (sends_due.size() == 0)
                begin
                    $error("result with no item outstanding: %p", result);
                    errs++;
                end
                else
                begin
                    due = sends_due.pop_front();
                    if (result.send_action !== due.send_action)
                    begin
                        $error("send_action: expected %0d, got %0d",
                               due.send_action, result.send_action);
                        errs++;
                    end
                    if (result.dest_node !== due.dest_node)
                    begin
                        $error("dest_node: expected %0d, got %0d",
                               due.dest_node, result.dest_node);
                        errs++;
                    end
                    if (result.send_time !== due.send_time)
                    begin
                        $error("send_time: expected %0d, got %0d",
                               due.send_time, result.send_time);
                        errs++;
                    end
                    if (result.grant !== due.grant)
                    begin
                        $error("grant: expected %0d, got %0d", due.grant, result.grant);
                        errs++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_OWN_NODE)
                    own_id = cfg_data[3:0];
                else
                    nodes_cfg = cfg_data;
            end
            if (start && !busy)
                sends_due.push_back(apply_event(msg));
            outstanding <= sends_due.size();
        end
    end

endmodule

// ----- tb/lamport_mutex_node_tb.sv -----
`timescale 1ns / 100ps

module lamport_mutex_node_tb;
    import lmn_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    lmn_in_t     msg;
    logic        result_valid;
    lmn_out_t    result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [4:0]  cfg_data;
    int unsigned fail_count;
    int unsigned outstanding;

    int unsigned sent_items;
    int unsigned burst_left;
    logic [15:0] lingering;

    lamport_mutex_node uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .msg          (msg),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    lamport_mutex_node_checker mutex_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .msg          (msg),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic lmn_time_t pick_stamp(input lmn_time_t tmax);
        return (tmax == TIME_MAX) ? $urandom : $urandom_range(0, tmax);
    endfunction

    function automatic logic [3:0] other_node(input logic [3:0] me);
        logic [3:0] s;
        s = 4'($urandom_range(0, 15));
        while (s == me)
            s = 4'($urandom_range(0, 15));
        return s;
    endfunction

    task automatic send_item(input logic [2:0] cmd, input logic [3:0] src,
                             input lmn_time_t stamp);
        lmn_in_t     it;
        int unsigned gap;
        it.command     = cmd;
        it.source_node = src;
        it.msg_time    = stamp;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 25);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        start <= 1'b1;
        msg   <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic go_idle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input lmn_cfg_idx_t idx, input logic [4:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one lock attempt: optional stray items, lock, competing requests and replies, releases, unlock
    task automatic run_round(input logic [3:0] own, input int n, input lmn_time_t tmax);
        int         replies;
        logic [3:0] s;
        replies = n - 1 + $urandom_range(0, 1);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                send_item(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                          pick_stamp(tmax));
        send_item(CMD_LOCK, 4'($urandom_range(0, 15)), pick_stamp(tmax));
        for (int k = 0; k < replies; k++)
        begin
            s = other_node(own);
            if ($urandom_range(0, 2) == 0)
            begin
                send_item(CMD_REQ, s, pick_stamp(tmax));
                lingering[s] = 1'b1;
            end
            if ($urandom_range(0, 9) != 0)
                send_item(CMD_OK, s, pick_stamp(tmax));
        end
        if ($urandom_range(0, 4) == 0)
            send_item(CMD_RELEASE, other_node(own), pick_stamp(tmax));
        for (int i = 0; i < MAX_NODES; i++)
            if (lingering[i] && $urandom_range(0, 6) != 0)
            begin
                send_item(CMD_RELEASE, 4'(i), pick_stamp(tmax));
                lingering[i] = 1'b0;
            end
        if ($urandom_range(0, 9) != 0)
            send_item(CMD_UNLOCK, 4'($urandom_range(0, 15)), pick_stamp(tmax));
    endtask

    // clear the table and leave the node idle before the next setting
    task automatic drain(input logic [3:0] own, input lmn_time_t tmax);
        for (int i = 0; i < MAX_NODES; i++)
            if (4'(i) != own)
                send_item(CMD_RELEASE, 4'(i), pick_stamp(tmax));
        repeat (MAX_NODES - 1)
            send_item(CMD_OK, other_node(own), pick_stamp(tmax));
        send_item(CMD_UNLOCK, 4'($urandom_range(0, 15)), pick_stamp(tmax));
        lingering = '0;
    endtask

    task automatic run_phase(input logic [4:0] own_data, input logic [4:0] count_data,
                             input int unsigned budget, input lmn_time_t tmax,
                             input bit flood);
        logic [3:0]  own;
        int          n;
        int unsigned stop_at;
        own = own_data[3:0];
        n   = (count_data == 0) ? 1 : (count_data > MAX_NODES) ? MAX_NODES : count_data;
        go_idle();
        write_reg(CFG_OWN_NODE, own_data);
        write_reg(CFG_NODE_COUNT, count_data);
        if (flood)
        begin
            repeat (20)
                send_item(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), $urandom);
            repeat (35)
                send_item(CMD_OK, other_node(own), $urandom);
            send_item(CMD_REQ, other_node(own), TIME_MAX);
        end
        stop_at = sent_items + budget;
        while (sent_items < stop_at)
            run_round(own, n, tmax);
        drain(own, tmax);
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        msg        <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_OWN_NODE;
        cfg_data   <= '0;
        sent_items = 0;
        burst_left = 0;
        lingering  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        go_idle();
        write_reg(CFG_OWN_NODE, 5'd3);
        write_reg(CFG_NODE_COUNT, 5'd4);
        send_item(3'd5, 4'd1, 32'd0);
        send_item(3'd7, 4'd15, 32'h7FFF_FFFF);
        send_item(CMD_UNLOCK, 4'd0, 32'd0);
        send_item(CMD_REQ, 4'd3, 32'd5);
        send_item(CMD_OK, 4'd1, 32'd2);
        send_item(CMD_LOCK, 4'd0, 32'd0);
        send_item(CMD_LOCK, 4'd0, 32'd0);
        send_item(CMD_REQ, 4'd0, 32'd1);
        send_item(CMD_OK, 4'd0, 32'd1);
        send_item(CMD_OK, 4'd15, 32'd1);
        send_item(CMD_OK, 4'd2, 32'd1);
        send_item(CMD_RELEASE, 4'd0, 32'd1);
        send_item(CMD_LOCK, 4'd0, 32'd0);
        send_item(CMD_REQ, 4'd15, 32'd0);
        send_item(CMD_UNLOCK, 4'd0, 32'd0);
        send_item(CMD_LOCK, 4'd0, 32'd0);
        send_item(CMD_OK, 4'd1, 32'd3);
        send_item(CMD_OK, 4'd2, 32'd3);
        send_item(CMD_REQ, 4'd4, 32'd3);
        send_item(CMD_OK, 4'd4, 32'd3);
        send_item(CMD_RELEASE, 4'd15, 32'd3);
        send_item(CMD_RELEASE, 4'd4, 32'd4);
        send_item(CMD_UNLOCK, 4'd0, 32'd0);
        send_item(3'd6, 4'd0, 32'd0);
        drain(4'd3, 32'd40);

        run_phase(5'd0, 5'd1, 70, 32'd20, 1'b0);
        run_phase(5'd15, 5'd16, 70, 32'd60, 1'b0);
        run_phase(5'd7, 5'd0, 70, 32'd150, 1'b0);
        run_phase(5'd12, 5'd31, 70, 32'd300, 1'b0);
        run_phase(5'd9, 5'd5, 70, 32'd600, 1'b0);
        run_phase(5'd1, 5'd2, 70, 32'd1200, 1'b0);
        run_phase(5'd31, 5'd17, 40, TIME_MAX, 1'b1);

        go_idle();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("lamport_mutex_node_tb OK");
        else
            $display("lamport_mutex_node_tb NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("lamport_mutex_node_tb NOT OK");
        $finish;
    end

endmodule
